[rtl/i2cbms_pkg.sv]
// Shared types and constants for the I2C bus master sequencer.
// Depends on nothing. The top level refers to it by scoped names.
package i2cbms_pkg;

	localparam int TPU_W = 10;
	localparam int POLL_W = 8;
	localparam int BYTE_W = 8;
	localparam int MODE_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W = 1;
	// A wait is at most four times the widest tick count.
	localparam int DELAY_W = TPU_W + 2;
	localparam int BITCNT_W = 4;

	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;
	localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 8'd250;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 1'd1;

	// Command codes.
	localparam logic [MODE_W-1:0] MODE_START = 3'd0;
	localparam logic [MODE_W-1:0] MODE_STOP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEND = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ = 3'd3;
	localparam logic [MODE_W-1:0] MODE_WAIT_ACK = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ACK = 3'd5;
	localparam logic [MODE_W-1:0] MODE_NACK = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST1,
		PH_ST2,
		PH_SP1,
		PH_SP2,
		PH_WA1,
		PH_WA2,
		PH_WAT,
		PH_AK1,
		PH_SB1,
		PH_SB2,
		PH_SB3,
		PH_RB1,
		PH_RB2
	} phase_t;

endpackage

[rtl/i2c_bus_master_sequencer.sv]
// I2C bus master sequencer top level: request input register, bus phase
// sequencer and result register. Depends on i2cbms_pkg.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  command_valid, mode, tx_byte, sda_sample
//   result    out        out_valid/out_stall  scl_level, sda_level, busy_res, done_res,
//                                             rx_byte, ack_timeout
//   config    in         cfg_we               cfg_index, cfg_data
//
// Every request stands for one tick of bus time and yields exactly one result.
// A request is held in the input register, then the phase sequencer updates
// its state and writes the result register, which drives the outputs; one
// request is taken every cycle while the result register is not stalled.
// Reset releases both bus lines, clears the sequencer to idle and loads the
// configuration defaults of 100 ticks per microsecond and a poll limit of 250.
// While the result register is full and stalled, the input register holds and
// in_stall rises only when the input register is also occupied.
module i2c_bus_master_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command_valid,
	input  logic [i2cbms_pkg::MODE_W-1:0]       mode,
	input  logic [i2cbms_pkg::BYTE_W-1:0]       tx_byte,
	input  logic                                sda_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                scl_level,
	output logic                                sda_level,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [i2cbms_pkg::BYTE_W-1:0]       rx_byte,
	output logic                                ack_timeout,
	input  logic                                cfg_we,
	input  logic [i2cbms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cbms_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [i2cbms_pkg::TPU_W-1:0]  tpu_q;
	logic [i2cbms_pkg::POLL_W-1:0] poll_limit_q;

	// Input register.
	logic                          valid_s1;
	logic                          cmd_valid_s1;
	logic [i2cbms_pkg::MODE_W-1:0] mode_s1;
	logic [i2cbms_pkg::BYTE_W-1:0] tx_byte_s1;
	logic                          sda_s1;

	// Sequencer state.
	i2cbms_pkg::phase_t              phase_q, phase_d;
	logic [i2cbms_pkg::MODE_W-1:0]   active_mode_q, active_mode_d;
	logic [i2cbms_pkg::DELAY_W-1:0]  delay_q, delay_d;
	logic [i2cbms_pkg::BITCNT_W-1:0] bit_count_q, bit_count_d;
	logic [i2cbms_pkg::BYTE_W-1:0]   shift_q, shift_d;
	logic [i2cbms_pkg::POLL_W-1:0]   poll_count_q, poll_count_d;
	logic                            scl_q, scl_d;
	logic                            sda_q, sda_d;
	logic                            timeout_q, timeout_d;
	logic [i2cbms_pkg::BYTE_W-1:0]   rx_q, rx_d;
	logic                            done_d;

	// Result register.
	logic                          valid_s2;
	logic                          scl_s2;
	logic                          sda_s2;
	logic                          busy_s2;
	logic                          done_s2;
	logic [i2cbms_pkg::BYTE_W-1:0] rx_s2;
	logic                          timeout_s2;

	logic advance;
	logic in_accept;

	// Wait lengths of one, two and four microseconds.
	logic [i2cbms_pkg::DELAY_W-1:0] wait1, wait2, wait4;
	logic                           wait_done;
	logic [i2cbms_pkg::DELAY_W-1:0] delay_dec;
	logic [i2cbms_pkg::BITCNT_W-1:0] bit_count_inc;

	// The input register moves into the sequencer whenever the result
	// register is empty or being drained this cycle.
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign wait1 = {2'b00, tpu_q};
	assign wait2 = {1'b0, tpu_q, 1'b0};
	assign wait4 = {tpu_q, 2'b00};

	// A wait counts down to one; a zero load still lasts one tick.
	assign wait_done = (delay_q <= i2cbms_pkg::DELAY_W'(1));
	assign delay_dec = wait_done ? '0 : delay_q - i2cbms_pkg::DELAY_W'(1);
	assign bit_count_inc = bit_count_q + i2cbms_pkg::BITCNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= i2cbms_pkg::TPU_RESET;
			poll_limit_q <= i2cbms_pkg::POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cbms_pkg::REG_TICKS_PER_US: begin
					tpu_q <= cfg_data[i2cbms_pkg::TPU_W-1:0];
				end
				i2cbms_pkg::REG_ACK_POLL_LIMIT: begin
					poll_limit_q <= cfg_data[i2cbms_pkg::POLL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_valid_s1 <= command_valid;
			mode_s1 <= mode;
			tx_byte_s1 <= tx_byte;
			sda_s1 <= sda_sample;
		end
	end

	// Sequencer state register; it steps once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cbms_pkg::PH_IDLE;
			active_mode_q <= '0;
			delay_q <= '0;
			bit_count_q <= '0;
			shift_q <= '0;
			poll_count_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			timeout_q <= 1'b0;
			rx_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			active_mode_q <= active_mode_d;
			delay_q <= delay_d;
			bit_count_q <= bit_count_d;
			shift_q <= shift_d;
			poll_count_q <= poll_count_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
			timeout_q <= timeout_d;
			rx_q <= rx_d;
		end
	end

	// Next state of the bus sequencer for one tick of bus time.
	always_comb begin
		phase_d = phase_q;
		active_mode_d = active_mode_q;
		delay_d = delay_q;
		bit_count_d = bit_count_q;
		shift_d = shift_q;
		poll_count_d = poll_count_q;
		scl_d = scl_q;
		sda_d = sda_q;
		timeout_d = timeout_q;
		rx_d = rx_q;
		done_d = 1'b0;

		case (phase_q)
			i2cbms_pkg::PH_IDLE: begin
				// Unused command codes leave the sequencer idle.
				if (cmd_valid_s1 && mode_s1 <= i2cbms_pkg::MODE_NACK) begin
					active_mode_d = mode_s1;
					case (mode_s1)
						i2cbms_pkg::MODE_START: begin
							sda_d = 1'b1;
							scl_d = 1'b1;
							delay_d = wait4;
							phase_d = i2cbms_pkg::PH_ST1;
						end
						i2cbms_pkg::MODE_STOP: begin
							sda_d = 1'b0;
							scl_d = 1'b1;
							delay_d = wait4;
							phase_d = i2cbms_pkg::PH_SP1;
						end
						i2cbms_pkg::MODE_SEND: begin
							bit_count_d = '0;
							sda_d = tx_byte_s1[i2cbms_pkg::BYTE_W-1];
							shift_d = {tx_byte_s1[i2cbms_pkg::BYTE_W-2:0], 1'b0};
							delay_d = wait2;
							phase_d = i2cbms_pkg::PH_SB1;
						end
						i2cbms_pkg::MODE_READ: begin
							bit_count_d = '0;
							shift_d = '0;
							scl_d = 1'b1;
							delay_d = wait2;
							phase_d = i2cbms_pkg::PH_RB1;
						end
						i2cbms_pkg::MODE_WAIT_ACK: begin
							sda_d = 1'b1;
							scl_d = 1'b1;
							poll_count_d = '0;
							timeout_d = 1'b0;
							delay_d = wait1;
							phase_d = i2cbms_pkg::PH_WA1;
						end
						i2cbms_pkg::MODE_ACK, i2cbms_pkg::MODE_NACK: begin
							sda_d = (mode_s1 == i2cbms_pkg::MODE_NACK);
							scl_d = 1'b1;
							delay_d = wait2;
							phase_d = i2cbms_pkg::PH_AK1;
						end
						default: begin
						end
					endcase
				end
			end
			i2cbms_pkg::PH_ST1: begin
				delay_d = delay_dec;
				if (wait_done) begin
					sda_d = 1'b0;
					delay_d = wait4;
					phase_d = i2cbms_pkg::PH_ST2;
				end
			end
			i2cbms_pkg::PH_SP1: begin
				delay_d = delay_dec;
				if (wait_done) begin
					sda_d = 1'b1;
					delay_d = wait4;
					phase_d = i2cbms_pkg::PH_SP2;
				end
			end
			i2cbms_pkg::PH_ST2, i2cbms_pkg::PH_SP2, i2cbms_pkg::PH_AK1: begin
				delay_d = delay_dec;
				if (wait_done) begin
					scl_d = 1'b0;
					sda_d = 1'b1;
					phase_d = i2cbms_pkg::PH_IDLE;
					done_d = 1'b1;
				end
			end
			i2cbms_pkg::PH_WA1: begin
				delay_d = delay_dec;
				if (wait_done) begin
					phase_d = i2cbms_pkg::PH_WA2;
				end
			end
			i2cbms_pkg::PH_WA2: begin
				if (!sda_s1) begin
					scl_d = 1'b0;
					phase_d = i2cbms_pkg::PH_IDLE;
					done_d = 1'b1;
				end else if (poll_count_q >= poll_limit_q) begin
					scl_d = 1'b0;
					timeout_d = 1'b1;
					phase_d = i2cbms_pkg::PH_WAT;
				end else begin
					poll_count_d = poll_count_q + i2cbms_pkg::POLL_W'(1);
				end
			end
			i2cbms_pkg::PH_WAT: begin
				// After a timeout the bus is released with a stop sequence.
				sda_d = 1'b0;
				scl_d = 1'b1;
				delay_d = wait4;
				phase_d = i2cbms_pkg::PH_SP1;
			end
			i2cbms_pkg::PH_SB1: begin
				delay_d = delay_dec;
				if (wait_done) begin
					scl_d = 1'b1;
					delay_d = wait2;
					phase_d = i2cbms_pkg::PH_SB2;
				end
			end
			i2cbms_pkg::PH_SB2: begin
				delay_d = delay_dec;
				if (wait_done) begin
					scl_d = 1'b0;
					delay_d = wait2;
					phase_d = i2cbms_pkg::PH_SB3;
				end
			end
			i2cbms_pkg::PH_SB3: begin
				delay_d = delay_dec;
				if (wait_done) begin
					bit_count_d = bit_count_inc;
					if (bit_count_inc < i2cbms_pkg::BITS_PER_BYTE) begin
						sda_d = shift_q[i2cbms_pkg::BYTE_W-1];
						shift_d = {shift_q[i2cbms_pkg::BYTE_W-2:0], 1'b0};
						delay_d = wait2;
						phase_d = i2cbms_pkg::PH_SB1;
					end else begin
						scl_d = 1'b0;
						sda_d = 1'b1;
						phase_d = i2cbms_pkg::PH_IDLE;
						done_d = 1'b1;
					end
				end
			end
			i2cbms_pkg::PH_RB1: begin
				// SDA is sampled at the end of the SCL high time.
				delay_d = delay_dec;
				if (wait_done) begin
					shift_d = {shift_q[i2cbms_pkg::BYTE_W-1:1], shift_q[0] | sda_s1};
					scl_d = 1'b0;
					delay_d = wait2;
					phase_d = i2cbms_pkg::PH_RB2;
				end
			end
			i2cbms_pkg::PH_RB2: begin
				delay_d = delay_dec;
				if (wait_done) begin
					bit_count_d = bit_count_inc;
					if (bit_count_inc < i2cbms_pkg::BITS_PER_BYTE) begin
						shift_d = {shift_q[i2cbms_pkg::BYTE_W-2:0], 1'b0};
						scl_d = 1'b1;
						delay_d = wait2;
						phase_d = i2cbms_pkg::PH_RB1;
					end else begin
						scl_d = 1'b0;
						sda_d = 1'b1;
						rx_d = shift_q;
						phase_d = i2cbms_pkg::PH_IDLE;
						done_d = 1'b1;
					end
				end
			end
			default: begin
				phase_d = i2cbms_pkg::PH_IDLE;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_s2 <= scl_d;
			sda_s2 <= sda_d;
			busy_s2 <= (phase_d != i2cbms_pkg::PH_IDLE);
			done_s2 <= done_d;
			rx_s2 <= rx_d;
			timeout_s2 <= timeout_d;
		end
	end

	assign out_valid = valid_s2;
	assign scl_level = scl_s2;
	assign sda_level = sda_s2;
	assign busy_res = busy_s2;
	assign done_res = done_s2;
	assign rx_byte = rx_s2;
	assign ack_timeout = timeout_s2;

	// A finished command always leaves the sequencer idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done pulse reported while still busy");

	// The tick after an acknowledge timeout keeps SCL pulled low.
	a_timeout_scl_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cbms_pkg::PH_WAT |-> !scl_q && timeout_q)
		else $error("timeout tick without SCL low and flag set");

	// The bit counter never runs past one byte.
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= i2cbms_pkg::BITS_PER_BYTE)
		else $error("bit counter beyond one byte");

	// The input register only stalls while the result register is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a held result");

endmodule
